### rtl/core/ahcid_pkg.sv
package ahcid_pkg;

	localparam int LINE_MAX_DEF = 64;
	localparam int ID_BYTES_DEF = 5;

	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] LEN_FLOOR = 7'd8;
	localparam logic [CNT_W-1:0] MIN_DIGITS_RST = 7'd8;
	localparam logic [CNT_W-1:0] TEN_DIGITS = 7'd10;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;

	typedef struct packed {
		logic       is_eol;
		logic       is_print;
		logic       is_hex;
		logic [3:0] nibble;
	} char_class_t;

endpackage

### rtl/core/ahcid_if.sv
interface ahcid_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface ahcid_id_if #(
	parameter int ID_BYTES = 5
);
	logic                  valid;
	logic                  ready;
	logic [8*ID_BYTES-1:0] card_id;
	logic [6:0]            digit_count;
	logic                  is_ten_digit;

	modport source (output valid, output card_id, output digit_count, output is_ten_digit,
		input ready);
	modport sink (input valid, input card_id, input digit_count, input is_ten_digit,
		output ready);
endinterface

### rtl/core/ascii_hex_card_id_line_parser_top.sv
// ASCII hex card ID line parser.
// rx_chan carries one received byte per item (valid/ready). Printable bytes
// are collected per line; CR or LF closes the line. A line of at least 8
// printable characters holding at least min_digits hex digits updates the
// kept card ID and sends one item on id_chan: the ID (first byte on top),
// the digit count and a ten-digit flag. Other line ends only clear the line.
// min_digits is loaded through cfg_we/cfg_wdata; the user must load it only
// while the block is idle; the block does not enforce this. A line-end byte
// waits in the input register before its result is registered in the output
// register. Throughput: one byte per cycle, set by the single registered pass
// from the input register through the line state into the output register,
// which lets a new byte be taken while a result waits; when the receiver
// stalls, bytes that produce no result keep flowing, and a line end stalls in
// the input register until the waiting result is taken. Reset clears the line
// counters, the kept ID and both registers, and loads min_digits with 8.
module ascii_hex_card_id_line_parser_top #(
	parameter int LINE_MAX = ahcid_pkg::LINE_MAX_DEF,
	parameter int ID_BYTES = ahcid_pkg::ID_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ahcid_rx_if.sink                    rx_chan,
	ahcid_id_if.source                  id_chan,
	input  logic                        cfg_we,
	input  logic [ahcid_pkg::CNT_W-1:0] cfg_wdata
);
	import ahcid_pkg::*;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic [CNT_W-1:0]      min_digits_q;
	logic                  out_valid_q;
	logic [8*ID_BYTES-1:0] card_id_q;
	logic [CNT_W-1:0]      digit_count_q;
	logic                  is_ten_q;

	char_class_t           cls;
	logic                  hit;
	logic                  advance;
	logic [8*ID_BYTES-1:0] res_id;
	logic [CNT_W-1:0]      res_count;
	logic                  res_ten;

	ahcid_char_class u_class (
		.char_in (char_s1),
		.cls     (cls)
	);

	ahcid_line_core #(
		.LINE_MAX (LINE_MAX),
		.ID_BYTES (ID_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.cls          (cls),
		.min_digits   (min_digits_q),
		.hit          (hit),
		.card_id      (res_id),
		.digit_count  (res_count),
		.is_ten_digit (res_ten)
	);

	assign advance = valid_s1 && !(hit && out_valid_q && !id_chan.ready);
	assign rx_chan.ready = !valid_s1 || advance;

	assign id_chan.valid        = out_valid_q;
	assign id_chan.card_id      = card_id_q;
	assign id_chan.digit_count  = digit_count_q;
	assign id_chan.is_ten_digit = is_ten_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= MIN_DIGITS_RST;
		end else if (cfg_we) begin
			min_digits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_chan.valid && rx_chan.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_chan.valid && rx_chan.ready) begin
			char_s1 <= rx_chan.char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (id_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			card_id_q     <= res_id;
			digit_count_q <= res_count;
			is_ten_q      <= res_ten;
		end
	end

endmodule

### rtl/core/ahcid_char_class.sv
module ahcid_char_class (
	input  logic [7:0]            char_in,
	output ahcid_pkg::char_class_t cls
);
	import ahcid_pkg::*;

	logic [7:0] nib_full;

	always_comb begin
		cls.is_eol   = (char_in == CHAR_CR) || (char_in == CHAR_LF);
		cls.is_print = char_in inside {[PRINT_LO:PRINT_HI]};
		cls.is_hex   = 1'b0;
		nib_full     = '0;
		if (char_in inside {[CHAR_0:CHAR_9]}) begin
			cls.is_hex = 1'b1;
			nib_full   = char_in - CHAR_0;
		end else if (char_in inside {[CHAR_UA:CHAR_UF]}) begin
			cls.is_hex = 1'b1;
			nib_full   = char_in - CHAR_UA + 8'd10;
		end else if (char_in inside {[CHAR_LA:CHAR_LF_HEX]}) begin
			cls.is_hex = 1'b1;
			nib_full   = char_in - CHAR_LA + 8'd10;
		end
		cls.nibble = nib_full[3:0];
	end

endmodule

### rtl/core/ahcid_line_core.sv
module ahcid_line_core #(
	parameter int LINE_MAX = ahcid_pkg::LINE_MAX_DEF,
	parameter int ID_BYTES = ahcid_pkg::ID_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  ahcid_pkg::char_class_t      cls,
	input  logic [ahcid_pkg::CNT_W-1:0] min_digits,
	output logic                        hit,
	output logic [8*ID_BYTES-1:0]       card_id,
	output logic [ahcid_pkg::CNT_W-1:0] digit_count,
	output logic                        is_ten_digit
);
	import ahcid_pkg::*;

	localparam int NIBBLES = 2 * ID_BYTES;
	localparam int ID_W = 8 * ID_BYTES;

	logic [CNT_W-1:0] line_chars_q;
	logic [CNT_W-1:0] hex_count_q;
	logic [ID_W-1:0]  line_nibbles_q;
	logic [ID_W-1:0]  kept_id_q;

	logic [CNT_W-1:0] pairs;
	logic [ID_W-1:0]  id_next;
	logic [ID_W-1:0]  nib_next;
	logic             room;

	assign hit = cls.is_eol && (line_chars_q >= LEN_FLOOR) && (hex_count_q >= min_digits);
	assign pairs = hex_count_q >> 1;
	// line_chars saturates at CNT_MAX, so compare one bit wider for large LINE_MAX
	assign room = {1'b0, line_chars_q} < (CNT_W + 1)'(LINE_MAX);

	always_comb begin
		for (int i = 0; i < ID_BYTES; i++) begin
			if (pairs > CNT_W'(i)) begin
				id_next[8*(ID_BYTES-1-i) +: 8] = line_nibbles_q[8*(ID_BYTES-1-i) +: 8];
			end else begin
				id_next[8*(ID_BYTES-1-i) +: 8] = kept_id_q[8*(ID_BYTES-1-i) +: 8];
			end
		end
	end

	always_comb begin
		nib_next = line_nibbles_q;
		for (int k = 0; k < NIBBLES; k++) begin
			if (hex_count_q == CNT_W'(NIBBLES - 1 - k)) begin
				nib_next[4*k +: 4] = cls.nibble;
			end
		end
	end

	assign card_id      = id_next;
	assign digit_count  = hex_count_q;
	assign is_ten_digit = (hex_count_q == TEN_DIGITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chars_q   <= '0;
			hex_count_q    <= '0;
			line_nibbles_q <= '0;
			kept_id_q      <= '0;
		end else if (step) begin
			if (cls.is_eol) begin
				if (hit) begin
					kept_id_q <= id_next;
				end
				line_chars_q   <= '0;
				hex_count_q    <= '0;
				line_nibbles_q <= '0;
			end else if (cls.is_print && room) begin
				if (line_chars_q != CNT_MAX) begin
					line_chars_q <= line_chars_q + 1'b1;
				end
				if (cls.is_hex) begin
					line_nibbles_q <= nib_next;
					if (hex_count_q != CNT_MAX) begin
						hex_count_q <= hex_count_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
